// ===== design/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg: shared types, constants and calendar functions
// Field widths, command codes and the Gregorian month and leap-year rules
// used by the date arithmetic unit and its weekday stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned AMT_W     = 18;
  localparam int unsigned WDAY_W    = 3;
  // signed day count: covers the widest year range plus the largest amount
  localparam int unsigned DAY_CNT_W = 22;
  // wide year value used for range checks before truncation
  localparam int unsigned WIDE_YR_W = 20;

  localparam int unsigned DEF_MIN_YEAR = 1900;
  localparam int unsigned DEF_MAX_YEAR = 2155;

  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 12'd1900;
  localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

  // command codes
  localparam logic [MODE_W-1:0] MODE_LOAD       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_DAYS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_MONTHS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD_YEARS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_DAY    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SET_MONTH  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SET_YEAR   = 3'd6;

  // reciprocal constants for division by a constant
  localparam logic [12:0] RECIP_100 = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [17:0] RECIP_12  = 18'd174763; // 2^21 / 12, rounded up
  localparam logic [8:0]  RECIP_7   = 9'd293;     // 2^11 / 7, rounded up

  // century of a year, exact for every 12-bit year
  function automatic logic [5:0] century(input logic [YEAR_W-1:0] y);
    logic [24:0] prod;
    prod = 25'(y) * 25'(RECIP_100);
    return prod[24:19];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [5:0] cent;
    logic       cent_hit;
    cent     = century(y);
    cent_hit = (12'(12'(cent) * 12'd100) == y);
    return (y[1:0] == 2'b00) && (!cent_hit || (cent[1:0] == 2'b00));
  endfunction

  function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = is_leap(y) ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [DAY_W-1:0]            d,
                                   input logic [MONTH_W-1:0]          m,
                                   input logic signed [WIDE_YR_W-1:0] y,
                                   input logic [YEAR_W-1:0]           ymin,
                                   input logic [YEAR_W-1:0]           ymax);
    logic yr_in;
    yr_in = (y >= $signed({8'd0, ymin})) && (y <= $signed({8'd0, ymax}));
    return yr_in && (m >= MONTH_FIRST) && (m <= MONTH_LAST) && (d != 5'd0)
           && (d <= month_len(m, y[YEAR_W-1:0]));
  endfunction

endpackage

`default_nettype wire

// ===== design/cda_weekday.sv =====
// ----------------------------------------------------------------------------
// cda_weekday: weekday of a date
// Four registered steps of the congruence rule: shift Jan/Feb into the
// previous year, split off the century, sum the terms, reduce mod 7.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_weekday import cda_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DAY_W-1:0]   day_i,
  input  wire logic [MONTH_W-1:0] month_i,
  input  wire logic [YEAR_W-1:0]  year_i,
  output logic                    done_o,
  output logic [WDAY_W-1:0]       weekday_o
);

  // month term of the rule, months three through fourteen
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  logic [3:0]         vld_q;
  logic [DAY_W-1:0]   s1_day_q, s2_day_q;
  logic [MONTH_W-1:0] s1_mon_q, s2_mon_q;
  logic [YEAR_W-1:0]  s1_yr_q, s2_yr_q;
  logic [5:0]         s2_cent_q;
  logic [8:0]         f_q;
  logic [WDAY_W-1:0]  wd_q;

  logic [MONTH_W-1:0] s1_mon_d;
  logic [YEAR_W-1:0]  s1_yr_d;
  logic [6:0]         yr_rem;
  logic [8:0]         f_d;
  logic [17:0]        f_prod;
  logic [6:0]         f_quo;
  logic [2:0]         f_rem;
  logic [3:0]         wd_sum;
  logic [WDAY_W-1:0]  wd_d;

  always_comb begin
    if (month_i < MONTH_MAR) begin
      s1_mon_d = 4'(month_i + MONTH_LAST);
      s1_yr_d  = 12'(year_i - 12'd1);
    end else begin
      s1_mon_d = month_i;
      s1_yr_d  = year_i;
    end
  end

  // year within century, then the term sum (at most 403)
  assign yr_rem = 7'(s2_yr_q - 12'(12'(s2_cent_q) * 12'd100));
  assign f_d    = 9'(s2_day_q) + 9'(month_term(s2_mon_q)) + 9'(yr_rem)
                + 9'(yr_rem[6:2]) + 9'(s2_cent_q[5:2]) + 9'(9'(s2_cent_q) * 9'd5);

  // f mod 7 by reciprocal, then shift so that Monday is zero
  assign f_prod = 18'(f_q) * 18'(RECIP_7);
  assign f_quo  = f_prod[17:11];
  assign f_rem  = 3'(f_q - 9'(9'(f_quo) * 9'd7));
  assign wd_sum = 4'(f_rem) + 4'd5;
  assign wd_d   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : 3'(wd_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_day_q  <= day_i;
    s1_mon_q  <= s1_mon_d;
    s1_yr_q   <= s1_yr_d;
    s2_day_q  <= s1_day_q;
    s2_mon_q  <= s1_mon_q;
    s2_yr_q   <= s1_yr_q;
    s2_cent_q <= century(s1_yr_q);
    f_q       <= f_d;
    if (vld_q[2]) begin
      wd_q <= wd_d;
    end
  end

  assign done_o    = vld_q[3];
  assign weekday_o = wd_q;

endmodule

`default_nettype wire

// ===== design/calendar_date_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit: Gregorian date register with arithmetic
// Holds one date and applies load, set and signed add commands to it,
// answering each command with the date, its weekday and an ok flag.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carries one command word (mode,
//   day, month, year, signed amount). output channel: out_valid_o /
//   out_stall_i carries one result word per command.
//   a word moves on a rising edge with valid high and stall low.
//   one command is worked at a time; in_stall_o is high from acceptance
//   until the result has been moved into the output register.
//   load, set and add-years commit in the decode step; add-months divides
//   the month index by twelve first. add-days runs one shared 22-bit adder
//   over a day count: it adds the length of each year from MIN_YEAR up to
//   the current year and of each month before the current month, then
//   walks again from MIN_YEAR, peeling whole years and months off the
//   count to find the target date.
//   the weekday goes through a four-step pipeline after every command.
//   the output register lets a new command be accepted while a result is
//   still waiting; if the receiver stalls at the end of the next command,
//   that command holds in its last state until the register frees up.
//   reset: date is 1 january 1900, no result pending, ready for a command.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_arithmetic_unit import cda_pkg::*; #(
  parameter int unsigned MIN_YEAR = DEF_MIN_YEAR,
  parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // command channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [MODE_W-1:0]       mode_i,
  input  wire logic [DAY_W-1:0]        day_in_i,
  input  wire logic [MONTH_W-1:0]      month_in_i,
  input  wire logic [YEAR_W-1:0]       year_in_i,
  input  wire logic signed [AMT_W-1:0] amount_i,
  // result channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [DAY_W-1:0]             day_out_o,
  output logic [MONTH_W-1:0]           month_out_o,
  output logic [YEAR_W-1:0]            year_out_o,
  output logic [WDAY_W-1:0]            weekday_o,
  output logic                         ok_o
);

  localparam logic [YEAR_W-1:0] MinYr = YEAR_W'(MIN_YEAR);
  localparam logic [YEAR_W-1:0] MaxYr = YEAR_W'(MAX_YEAR);

  // sequencer states
  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_EXEC    = 13'b0000000000010,  // decode, one-step commands commit here
    ST_FWD_YR  = 13'b0000000000100,  // count days of whole years
    ST_FWD_MO  = 13'b0000000001000,  // count days of whole months
    ST_ADD_AMT = 13'b0000000010000,  // add the signed amount
    ST_ADD_DAY = 13'b0000000100000,  // add the day of month
    ST_BWD_YR  = 13'b0000001000000,  // peel whole years off the count
    ST_BWD_MO  = 13'b0000010000000,  // peel whole months off the count
    ST_MDIV    = 13'b0000100000000,  // month index divided by twelve
    ST_MFIN    = 13'b0001000000000,  // month remainder and range check
    ST_WDAY    = 13'b0010000000000,  // kick off the weekday pipeline
    ST_WAIT    = 13'b0100000000000,  // wait for the weekday
    ST_DONE    = 13'b1000000000000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;

  // captured command
  logic [MODE_W-1:0]       mode_q;
  logic [DAY_W-1:0]        day_in_q;
  logic [MONTH_W-1:0]      month_in_q;
  logic [YEAR_W-1:0]       year_in_q;
  logic signed [AMT_W-1:0] amount_q;

  // date register
  logic [DAY_W-1:0]   cur_day_q, cur_day_d;
  logic [MONTH_W-1:0] cur_month_q, cur_month_d;
  logic [YEAR_W-1:0]  cur_year_q, cur_year_d;
  logic               ok_q, ok_d;

  // walk registers
  logic signed [DAY_CNT_W-1:0] acc_q, acc_d;
  logic [YEAR_W-1:0]           yr_q, yr_d;
  logic [MONTH_W-1:0]          mo_q, mo_d;
  logic [14:0]                 quo_q, quo_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [DAY_W-1:0]   day_out_q;
  logic [MONTH_W-1:0] month_out_q;
  logic [YEAR_W-1:0]  year_out_q;
  logic [WDAY_W-1:0]  weekday_q;
  logic               ok_out_q;

  logic in_acc;
  logic out_free;
  logic out_load;

  // shared adder: every step of the day walk goes through it
  logic signed [DAY_CNT_W-1:0] add_b;
  logic signed [DAY_CNT_W-1:0] add_sum;

  logic signed [DAY_CNT_W-1:0] mon_idx;
  logic signed [WIDE_YR_W-1:0] yr_plus;
  logic [35:0]                 div_prod;
  logic [17:0]                 mon_rem;
  logic [MONTH_W-1:0]          mfin_mon;

  logic              wd_start;
  logic              wd_done;
  logic [WDAY_W-1:0] wd_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;
  assign wd_start   = (state_q == ST_WDAY);

  always_comb begin
    case (state_q)
      ST_FWD_YR:  add_b = DAY_CNT_W'(year_len(yr_q));
      ST_FWD_MO:  add_b = DAY_CNT_W'(month_len(mo_q, cur_year_q));
      ST_ADD_AMT: add_b = DAY_CNT_W'(amount_q);
      ST_ADD_DAY: add_b = DAY_CNT_W'(cur_day_q);
      // backward steps subtract; a negative sum means the count is shorter
      ST_BWD_YR:  add_b = -DAY_CNT_W'(year_len(yr_q));
      ST_BWD_MO:  add_b = -DAY_CNT_W'(month_len(mo_q, yr_q));
      default:    add_b = '0;
    endcase
  end

  assign add_sum = acc_q + add_b;

  // month index: year * 12 + month - 1 + amount
  assign mon_idx = $signed(DAY_CNT_W'({cur_year_q, 3'b000})
                         + DAY_CNT_W'({cur_year_q, 2'b00})
                         + DAY_CNT_W'(cur_month_q) - DAY_CNT_W'(1))
                 + DAY_CNT_W'(amount_q);
  assign yr_plus = $signed({8'd0, cur_year_q}) + WIDE_YR_W'(amount_q);

  // index is known non-negative and below 2^18 when this is used
  assign div_prod = 36'(acc_q[17:0]) * 36'(RECIP_12);
  assign mon_rem  = acc_q[17:0] - 18'({quo_q, 3'b000}) - 18'({quo_q, 2'b00});
  assign mfin_mon = 4'(mon_rem[3:0] + 4'd1);

  always_comb begin
    state_d     = state_q;
    cur_day_d   = cur_day_q;
    cur_month_d = cur_month_q;
    cur_year_d  = cur_year_q;
    ok_d        = ok_q;
    acc_d       = acc_q;
    yr_d        = yr_q;
    mo_d        = mo_q;
    quo_d       = quo_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ok_d    = 1'b0;
        state_d = ST_WDAY;
        case (mode_q)
          MODE_LOAD: begin
            if (date_ok(day_in_q, month_in_q, $signed({8'd0, year_in_q}), MinYr, MaxYr)) begin
              cur_day_d   = day_in_q;
              cur_month_d = month_in_q;
              cur_year_d  = year_in_q;
              ok_d        = 1'b1;
            end else begin
              // invalid load falls back to the first day of the range
              cur_day_d   = DAY_FIRST;
              cur_month_d = MONTH_FIRST;
              cur_year_d  = MinYr;
            end
          end
          MODE_ADD_DAYS: begin
            // count starts at -1 so adding the day gives a zero-based count
            acc_d   = -DAY_CNT_W'(1);
            yr_d    = MinYr;
            mo_d    = MONTH_FIRST;
            state_d = ST_FWD_YR;
          end
          MODE_ADD_MONTHS: begin
            acc_d   = mon_idx;
            state_d = ST_MDIV;
          end
          MODE_ADD_YEARS: begin
            if (date_ok(cur_day_q, cur_month_q, yr_plus, MinYr, MaxYr)) begin
              cur_year_d = yr_plus[YEAR_W-1:0];
              ok_d       = 1'b1;
            end
          end
          MODE_SET_DAY: begin
            if (date_ok(day_in_q, cur_month_q, $signed({8'd0, cur_year_q}), MinYr, MaxYr)) begin
              cur_day_d = day_in_q;
              ok_d      = 1'b1;
            end
          end
          MODE_SET_MONTH: begin
            if (date_ok(cur_day_q, month_in_q, $signed({8'd0, cur_year_q}), MinYr, MaxYr)) begin
              cur_month_d = month_in_q;
              ok_d        = 1'b1;
            end
          end
          MODE_SET_YEAR: begin
            if (date_ok(cur_day_q, cur_month_q, $signed({8'd0, year_in_q}), MinYr, MaxYr)) begin
              cur_year_d = year_in_q;
              ok_d       = 1'b1;
            end
          end
          default: begin
            // unused code: no change, ok stays low
          end
        endcase
      end

      ST_FWD_YR: begin
        if (yr_q < cur_year_q) begin
          acc_d = add_sum;
          yr_d  = 12'(yr_q + 12'd1);
        end else begin
          state_d = ST_FWD_MO;
        end
      end

      ST_FWD_MO: begin
        if (mo_q < cur_month_q) begin
          acc_d = add_sum;
          mo_d  = 4'(mo_q + 4'd1);
        end else begin
          state_d = ST_ADD_AMT;
        end
      end

      ST_ADD_AMT: begin
        acc_d   = add_sum;
        state_d = ST_ADD_DAY;
      end

      ST_ADD_DAY: begin
        acc_d   = add_sum;
        yr_d    = MinYr;
        mo_d    = MONTH_FIRST;
        state_d = ST_BWD_YR;
      end

      ST_BWD_YR: begin
        if (acc_q[DAY_CNT_W-1]) begin
          // target lies before the first day of the range
          state_d = ST_WDAY;
        end else if (add_sum[DAY_CNT_W-1]) begin
          state_d = ST_BWD_MO;
        end else if (yr_q == MaxYr) begin
          // target lies past the last day of the range
          state_d = ST_WDAY;
        end else begin
          acc_d = add_sum;
          yr_d  = 12'(yr_q + 12'd1);
        end
      end

      ST_BWD_MO: begin
        if ((mo_q != MONTH_LAST) && !add_sum[DAY_CNT_W-1]) begin
          acc_d = add_sum;
          mo_d  = 4'(mo_q + 4'd1);
        end else begin
          // remainder is below the month length, so the date is valid
          cur_day_d   = 5'(acc_q[DAY_W-1:0] + 5'd1);
          cur_month_d = mo_q;
          cur_year_d  = yr_q;
          ok_d        = 1'b1;
          state_d     = ST_WDAY;
        end
      end

      ST_MDIV: begin
        if (acc_q[DAY_CNT_W-1]) begin
          state_d = ST_WDAY;
        end else begin
          quo_d   = div_prod[35:21];
          state_d = ST_MFIN;
        end
      end

      ST_MFIN: begin
        if (date_ok(cur_day_q, mfin_mon, $signed({5'd0, quo_q}), MinYr, MaxYr)) begin
          cur_month_d = mfin_mon;
          cur_year_d  = quo_q[YEAR_W-1:0];
          ok_d        = 1'b1;
        end
        state_d = ST_WDAY;
      end

      ST_WDAY: begin
        state_d = ST_WAIT;
      end

      ST_WAIT: begin
        if (wd_done) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_day_q   <= DAY_FIRST;
      cur_month_q <= MONTH_FIRST;
      cur_year_q  <= RESET_YEAR;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_day_q   <= cur_day_d;
      cur_month_q <= cur_month_d;
      cur_year_q  <= cur_year_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, walk and output registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q     <= mode_i;
      day_in_q   <= day_in_i;
      month_in_q <= month_in_i;
      year_in_q  <= year_in_i;
      amount_q   <= amount_i;
    end
    acc_q <= acc_d;
    yr_q  <= yr_d;
    mo_q  <= mo_d;
    quo_q <= quo_d;
    if (out_load) begin
      day_out_q   <= cur_day_q;
      month_out_q <= cur_month_q;
      year_out_q  <= cur_year_q;
      weekday_q   <= wd_val;
      ok_out_q    <= ok_q;
    end
  end

  cda_weekday u_weekday (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (wd_start),
    .day_i     (cur_day_q),
    .month_i   (cur_month_q),
    .year_i    (cur_year_q),
    .done_o    (wd_done),
    .weekday_o (wd_val)
  );

  assign out_valid_o = out_valid_q;
  assign day_out_o   = day_out_q;
  assign month_out_o = month_out_q;
  assign year_out_o  = year_out_q;
  assign weekday_o   = weekday_q;
  assign ok_o        = ok_out_q;

  // the held date is always a legal date of the configured range
  a_date_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_ok(cur_day_q, cur_month_q, $signed({8'd0, cur_year_q}), MinYr, MaxYr))
    else $error("date register holds an illegal date");

  // an accepted command is decoded in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC))
    else $error("accepted command not decoded");

  // weekday pipeline finishes only while the sequencer waits for it
  a_wday_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wd_done |-> (state_q == ST_WAIT))
    else $error("weekday result outside the wait state");

  // a new result appears only from the hand-off state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result word raised outside hand-off");

endmodule

`default_nettype wire
